// ===== hw/rtl/afr_pkg.sv =====
// Shared types and constants for the aim frame receiver.
`default_nettype none

package afr_pkg;

  // Header bytes and checksum offset
  localparam logic [7:0]  HEADER_FIRST  = 8'hFF;
  localparam logic [7:0]  HEADER_SECOND = 8'h00;
  localparam logic [15:0] SUM_OFFSET    = 16'd255;

  // frame_mode register codes
  localparam logic [1:0] MODE_IGNORE = 2'd0;
  localparam logic [1:0] MODE_AIM    = 2'd1;
  localparam logic [1:0] MODE_TARGET = 2'd2;
  localparam logic [1:0] MODE_RESET  = MODE_AIM;

  // frame_kind codes
  localparam logic KIND_AIM    = 1'b0;
  localparam logic KIND_TARGET = 1'b1;

  // Byte position codes: hunting, waiting for second header byte,
  // then payload index plus two
  localparam int unsigned POS_W       = 4;
  localparam logic [POS_W-1:0] POS_HUNT     = 4'd0;
  localparam logic [POS_W-1:0] POS_WAIT     = 4'd1;
  localparam logic [POS_W-1:0] POS_PAYLOAD  = 4'd2;
  localparam logic [POS_W-1:0] POS_LAST_AIM = 4'd9;
  localparam logic [POS_W-1:0] POS_LAST_TGT = 4'd7;

  localparam int unsigned PAYLOAD_DEPTH = 7;
  localparam int unsigned PAYLOAD_IDX_W = 3;

  // One result item; yaw sits in the lowest bits of tdata
  typedef struct packed {
    logic [15:0] distance_hundredths;
    logic [15:0] pitch_hundredths;
    logic [15:0] yaw_hundredths;
  } angles_t;

  typedef struct packed {
    logic    frame_kind;
    angles_t angles;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/aim_frame_receiver_core.sv =====
// Aim frame receiver: byte stream in, checked angle frames out.
//
// Input channel s_axis_*: one received serial byte per item. The block
// hunts for 0xFF, waits for 0x00, then gathers little-endian words:
// yaw, pitch, distance, checksum (aiming mode) or yaw, pitch, checksum
// (target mode). A frame whose checksum equals the 16-bit sum of the
// values plus 255 yields one item on m_axis_*; bad frames, and target
// frames repeating the last accepted yaw and pitch, yield nothing.
// Configuration channel cfg_*: writes frame_mode (0 ignore, 1 aiming,
// 2 target); always ready, write only while idle.
// Throughput: one byte per cycle while s_axis_tready is high. The byte is decoded
// and the checksum compared in the cycle it is accepted, and a good result is
// registered in the output register, or in the skid register when that is held.
// An output register plus one skid register sit on the result side; input
// stays ready while a result waits and drops only when both are full.
// Reset (rst, synchronous) sets frame_mode to aiming, returns to hunting,
// clears the last target angles and empties both output registers.
`default_nettype none

module aim_frame_receiver_core
  import afr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Byte input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // Frame output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [15:0] yaw, [31:16] pitch, [47:32] distance
  output logic             m_axis_tuser,   // [0] frame_kind
  // Configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data        // frame_mode
);

  logic [1:0]       frame_mode;
  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] byte_position_next;
  logic [7:0]       payload_bytes [PAYLOAD_DEPTH];
  logic [15:0]      last_target_yaw;
  logic [15:0]      last_target_pitch;

  result_t out_data;
  logic    out_valid;
  result_t skid_data;
  logic    skid_valid;

  logic             in_accept;
  logic [7:0]       rx_byte;
  logic             mode_active;
  logic [POS_W-1:0] last_pos;
  logic             store_byte;
  logic             final_byte;
  logic [15:0]      yaw;
  logic [15:0]      pitch;
  logic [15:0]      dist_word;
  logic [15:0]      check_aim;
  logic [15:0]      check_tgt;
  logic [15:0]      sum_aim;
  logic [15:0]      sum_tgt;
  logic             hit;
  logic             target_new;
  result_t          new_result;

  assign s_axis_tready = !skid_valid;
  assign cfg_ready     = 1'b1;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign rx_byte       = s_axis_tdata;

  // Mode decode
  always_comb begin
    mode_active = 1'b1;
    last_pos    = POS_LAST_AIM;
    unique case (frame_mode)
      MODE_AIM:    last_pos = POS_LAST_AIM;
      MODE_TARGET: last_pos = POS_LAST_TGT;
      default:     mode_active = 1'b0;
    endcase
  end

  // Assemble words; final byte is the checksum high byte
  assign yaw       = {payload_bytes[1], payload_bytes[0]};
  assign pitch     = {payload_bytes[3], payload_bytes[2]};
  assign dist_word = {payload_bytes[5], payload_bytes[4]};
  assign check_aim = {rx_byte, payload_bytes[6]};
  assign check_tgt = {rx_byte, payload_bytes[4]};
  assign sum_tgt   = yaw + pitch + SUM_OFFSET;
  assign sum_aim   = sum_tgt + dist_word;

  assign target_new = (yaw != last_target_yaw) || (pitch != last_target_pitch);

  // Position update and frame check
  always_comb begin
    byte_position_next = byte_position;
    store_byte         = 1'b0;
    final_byte         = 1'b0;
    if (mode_active) begin
      if (byte_position == POS_HUNT) begin
        if (rx_byte == HEADER_FIRST) byte_position_next = POS_WAIT;
      end else if (byte_position == POS_WAIT) begin
        if (rx_byte == HEADER_SECOND) byte_position_next = POS_PAYLOAD;
      end else if (byte_position > last_pos) begin
        byte_position_next = POS_HUNT;
      end else if (byte_position < last_pos) begin
        store_byte         = 1'b1;
        byte_position_next = byte_position + POS_WAIT;
      end else begin
        final_byte         = 1'b1;
        byte_position_next = POS_HUNT;
      end
    end
  end

  always_comb begin
    new_result.angles.yaw_hundredths   = yaw;
    new_result.angles.pitch_hundredths = pitch;
    if (frame_mode == MODE_AIM) begin
      new_result.frame_kind                 = KIND_AIM;
      new_result.angles.distance_hundredths = dist_word;
      hit = final_byte && (sum_aim == check_aim);
    end else begin
      new_result.frame_kind                 = KIND_TARGET;
      new_result.angles.distance_hundredths = '0;
      hit = final_byte && (sum_tgt == check_tgt) && target_new;
    end
  end

  // Control state and last target angles
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode        <= MODE_RESET;
      byte_position     <= POS_HUNT;
      last_target_yaw   <= '0;
      last_target_pitch <= '0;
    end else begin
      if (cfg_valid && cfg_ready) frame_mode <= cfg_data;
      if (in_accept) begin
        byte_position <= byte_position_next;
        if (hit && new_result.frame_kind == KIND_TARGET) begin
          last_target_yaw   <= yaw;
          last_target_pitch <= pitch;
        end
      end
    end
  end

  // Payload bytes, no reset
  always_ff @(posedge clk) begin
    if (in_accept && store_byte)
      payload_bytes[PAYLOAD_IDX_W'(byte_position - POS_PAYLOAD)] <= rx_byte;
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept && hit;
      end
    end else if (in_accept && hit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      if (skid_valid) out_data <= skid_data;
      else            out_data <= new_result;
    end else if (in_accept && hit) begin
      skid_data <= new_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data.angles;
  assign m_axis_tuser  = out_data.frame_kind;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while output is empty");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_LAST_AIM)
    else $error("byte position beyond longest frame");

  a_target_dist_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_TARGET) |-> (m_axis_tdata[47:32] == 16'd0))
    else $error("target frame with nonzero distance");

  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(s_axis_tready) |-> (out_valid && $past(hit && in_accept)))
    else $error("input stalled without a waiting result");

endmodule

`default_nettype wire

// ===== tb/tb_aim_frame_receiver_core.sv =====
// Self-checking testbench for the aim frame receiver core: byte stream in, angle frames out.
`default_nettype none

module tb_aim_frame_receiver_core;
  import afr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int RANDOM_ITEMS  = 520;
  localparam int SETTLE_CYCLES = 4;       // wait before a mode write once no frames are pending
  localparam int STALL_CYCLES  = 300;     // long sink hold-off to fill the output side
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int N_ROWS        = 31;

  typedef enum logic [0:0] {ROW_BYTE, ROW_MODE} row_op_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_FRAME} row_chk_e;

  // One directed step: a byte or a mode write, with an optional typed-in result
  typedef struct packed {
    row_op_e     op;
    logic [7:0]  value;
    row_chk_e    chk;
    result_t     frame;
  } row_t;

  localparam result_t NO_FRAME     = '0;
  localparam result_t AIM_EXTREMES = {KIND_AIM, 16'h0000, 16'h8000, 16'h7FFF};
  localparam result_t TGT_MINUS1   = {KIND_TARGET, 16'h0000, 16'hFFFF, 16'hFFFF};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;     // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;          // [15:0] yaw, [31:16] pitch, [47:32] distance
  logic        m_axis_tuser;          // [0] frame_kind
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = MODE_RESET;

  aim_frame_receiver_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // Clock: 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver-side model state
  logic [1:0]  mode_q = MODE_RESET;
  logic [3:0]  pos_q = POS_HUNT;
  logic [7:0]  payload_q [PAYLOAD_DEPTH] = '{default: 8'h00};
  logic [15:0] last_yaw_q = '0;
  logic [15:0] last_pitch_q = '0;

  result_t     pending_frames [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          bytes_taken = 0;
  int          aim_frames_seen = 0;
  int          target_frames_seen = 0;
  int          input_stall_cycles = 0;
  int          mode_writes = 0;
  bit          no_idle = 1'b0;
  bit          stall_request = 1'b0;

  row_t        directed_rows [0:N_ROWS-1];

  // Frame decoder: advances the model by one byte, returns 1 when a frame comes out
  function automatic bit decode_byte(input logic [7:0] b, output result_t r);
    logic [3:0]  end_pos;
    logic [15:0] yaw, pitch, dist_word, check;
    r = '0;
    if (mode_q == MODE_AIM) end_pos = POS_LAST_AIM;
    else if (mode_q == MODE_TARGET) end_pos = POS_LAST_TGT;
    else return 1'b0;

    if (pos_q == POS_HUNT) begin
      if (b == HEADER_FIRST) pos_q = POS_WAIT;
      return 1'b0;
    end
    if (pos_q == POS_WAIT) begin
      if (b == HEADER_SECOND) pos_q = POS_PAYLOAD;
      return 1'b0;
    end
    // left over from a longer frame layout: drop and hunt again
    if (pos_q > end_pos) begin
      pos_q = POS_HUNT;
      return 1'b0;
    end
    if (pos_q < end_pos) begin
      payload_q[pos_q - POS_PAYLOAD] = b;
      pos_q = pos_q + 4'd1;
      return 1'b0;
    end

    // last byte: high half of the checksum word
    pos_q = POS_HUNT;
    yaw   = {payload_q[1], payload_q[0]};
    pitch = {payload_q[3], payload_q[2]};
    if (mode_q == MODE_AIM) begin
      dist_word = {payload_q[5], payload_q[4]};
      check     = {b, payload_q[6]};
      if (check != 16'(yaw + pitch + dist_word + SUM_OFFSET)) return 1'b0;
      r = {KIND_AIM, dist_word, pitch, yaw};
      return 1'b1;
    end
    check = {b, payload_q[4]};
    if (check != 16'(yaw + pitch + SUM_OFFSET)) return 1'b0;
    if (yaw == last_yaw_q && pitch == last_pitch_q) return 1'b0;
    last_yaw_q   = yaw;
    last_pitch_q = pitch;
    r = {KIND_TARGET, 16'h0000, pitch, yaw};
    return 1'b1;
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 11))
      0:       return 16'h0000;
      1:       return 16'h7FFF;
      2:       return 16'h8000;
      3:       return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Offer one byte, with random gaps; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input row_chk_e chk, input result_t typed);
    result_t r;
    bit      has;
    while (!no_idle && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    bytes_taken++;
    has = decode_byte(b, r);
    case (chk)
      CHK_MODEL: if (has) pending_frames.push_back(r);
      CHK_FRAME: pending_frames.push_back(typed);
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Mode write, only once the block has nothing left to deliver
  task automatic set_mode(input logic [1:0] m);
    s_axis_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    mode_q = m;
    mode_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One frame in the layout of the current mode; faults adds noise and bad checksums,
  // partial cuts the frame short so the next bytes land mid-frame
  task automatic send_frame(input bit tgt, input bit faults, input bit partial);
    logic [7:0]  frame_bytes [$];
    logic [15:0] vals [3];
    logic [15:0] check;
    int          nvals;
    int          keep;
    nvals = tgt ? 2 : 3;
    if (faults && $urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(0, 254)));
    frame_bytes.push_back(HEADER_FIRST);
    // repeated header or junk while waiting for the second header byte
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3))
        frame_bytes.push_back($urandom_range(0, 2) == 0 ? HEADER_FIRST
                                                        : 8'($urandom_range(1, 255)));
    frame_bytes.push_back(HEADER_SECOND);
    if (tgt && $urandom_range(0, 3) == 0) begin
      vals[0] = last_yaw_q;
      vals[1] = last_pitch_q;
    end else begin
      for (int i = 0; i < 3; i++) vals[i] = rand_word();
    end
    check = SUM_OFFSET;
    for (int i = 0; i < nvals; i++) begin
      check = check + vals[i];
      frame_bytes.push_back(vals[i][7:0]);
      frame_bytes.push_back(vals[i][15:8]);
    end
    if (faults && $urandom_range(0, 6) == 0) check = check ^ 16'($urandom_range(1, 65535));
    frame_bytes.push_back(check[7:0]);
    frame_bytes.push_back(check[15:8]);
    if (partial) begin
      keep = ($urandom_range(0, 1) == 0) ? frame_bytes.size() - $urandom_range(1, 2)
                                         : $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
    end
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], CHK_MODEL, NO_FRAME);
  endtask

  // Sink: random back-pressure, plus one long hold-off on request
  initial begin : sink_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) < 8) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Output check against the oldest pending frame
  always @(posedge clk) begin
    result_t want;
    cycle_count++;
    if (!rst && s_axis_tvalid && !s_axis_tready) input_stall_cycles++;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (m_axis_tuser == KIND_AIM) aim_frames_seen++;
      else target_frames_seen++;
      if (pending_frames.size() == 0) begin
        $error("unexpected frame: kind %0d tdata %h", m_axis_tuser, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_frames.pop_front();
        if (m_axis_tuser !== want.frame_kind) begin
          $error("frame_kind: expected %0d, got %0d", want.frame_kind, m_axis_tuser);
          mismatch_count++;
        end
        if (m_axis_tdata[15:0] !== want.angles.yaw_hundredths) begin
          $error("yaw_hundredths: expected %0d, got %0d",
                 $signed(want.angles.yaw_hundredths), $signed(m_axis_tdata[15:0]));
          mismatch_count++;
        end
        if (m_axis_tdata[31:16] !== want.angles.pitch_hundredths) begin
          $error("pitch_hundredths: expected %0d, got %0d",
                 $signed(want.angles.pitch_hundredths), $signed(m_axis_tdata[31:16]));
          mismatch_count++;
        end
        if (m_axis_tdata[47:32] !== want.angles.distance_hundredths) begin
          $error("distance_hundredths: expected %0d, got %0d",
                 $signed(want.angles.distance_hundredths), $signed(m_axis_tdata[47:32]));
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("tb_aim_frame_receiver_core NOT OK");
    $finish;
  end

  initial begin : stimulus
    int  phase;
    int  nframes;
    int  pick;
    int  drain;
    int  goal;
    bit  tgt;

    // Directed: extreme aim values behind a repeated header, zero target frame
    // suppressed after reset, all-ones target, then ignore and unused modes
    directed_rows = '{
      '{ROW_BYTE, 8'hFF, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'hFF, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'h00, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'hFF, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'h7F, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'h00, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'h80, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'h00, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'h00, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'hFE, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'h00, CHK_FRAME, AIM_EXTREMES},
      '{ROW_MODE, 8'(MODE_TARGET), CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'hFF, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'h00, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'h00, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'h00, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'h00, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'h00, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'hFF, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'h00, CHK_NONE,  NO_FRAME},
      '{ROW_BYTE, 8'hFF, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'h00, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'hFF, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'hFF, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'hFF, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'hFF, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'hFD, CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'h00, CHK_FRAME, TGT_MINUS1},
      '{ROW_MODE, 8'(MODE_IGNORE), CHK_MODEL, NO_FRAME},
      '{ROW_BYTE, 8'hFF, CHK_MODEL, NO_FRAME},
      '{ROW_MODE, 8'(MODE_UNUSED), CHK_MODEL, NO_FRAME}
    };

    // Reset
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_MODE) set_mode(directed_rows[i].value[1:0]);
      else send_byte(directed_rows[i].value, directed_rows[i].chk, directed_rows[i].frame);
    end
    send_byte(8'h00, CHK_MODEL, NO_FRAME);   // dropped in the unused mode

    // Random phases: a mode write (often mid-frame), then frames, noise and cut frames
    goal  = bytes_taken + RANDOM_ITEMS;
    phase = 0;
    while (bytes_taken < goal) begin
      phase++;
      no_idle = (phase >= 5 && phase <= 7);
      if (phase == 3) begin
        // output side held off while aim frames keep coming
        set_mode(MODE_AIM);
        stall_request = 1'b1;
        repeat (8) send_frame(1'b0, 1'b0, 1'b0);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          set_mode(pick == 0 ? MODE_IGNORE : MODE_UNUSED);
          repeat ($urandom_range(3, 10)) send_byte(8'($urandom()), CHK_MODEL, NO_FRAME);
        end else begin
          tgt = (pick >= 6);
          set_mode(tgt ? MODE_TARGET : MODE_AIM);
          nframes = $urandom_range(2, 6);
          repeat (nframes) begin
            case ($urandom_range(0, 9))
              0:       repeat ($urandom_range(1, 6))
                         send_byte(8'($urandom()), CHK_MODEL, NO_FRAME);
              1:       send_frame(tgt, 1'b1, 1'b1);
              default: send_frame(tgt, 1'b1, 1'b0);
            endcase
          end
          if ($urandom_range(0, 2) == 0) send_frame(tgt, 1'b1, 1'b1);
        end
      end
    end
    no_idle = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Drain
    drain = 0;
    while (pending_frames.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (pending_frames.size() != 0) begin
      $error("%0d expected frames never arrived", pending_frames.size());
      mismatch_count++;
    end

    $display("%0d bytes sent over %0d phases, %0d mode writes",
             bytes_taken, phase, mode_writes);
    $display("frames out: %0d aim, %0d target; input held off for %0d cycles",
             aim_frames_seen, target_frames_seen, input_stall_cycles);
    if (mismatch_count == 0) begin
      $display("tb_aim_frame_receiver_core OK");
    end else begin
      $display("tb_aim_frame_receiver_core NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
